// ===== src/ppbd_pkg.sv =====
package ppbd_pkg;

   localparam int ADDR_WIDTH = 14;
   localparam int DATA_WIDTH = 8;

   localparam int NAMETABLE_BYTES_DEFAULT = 1024;
   localparam int PALETTE_ENTRIES_DEFAULT = 32;

   localparam logic [ADDR_WIDTH-1:0] NAMETABLE_BASE = 14'h2000;
   localparam logic [ADDR_WIDTH-1:0] NAMETABLE_LAST = 14'h3EFF;
   localparam logic [ADDR_WIDTH-1:0] MIRROR_BASE    = 14'h3000;
   localparam logic [ADDR_WIDTH-1:0] PALETTE_MASK   = 14'h001F;

   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   localparam logic MIRROR_HORIZONTAL = 1'b0;
   localparam logic MIRROR_VERTICAL   = 1'b1;

   typedef enum logic [1:0] {
      REGION_CARTRIDGE,
      REGION_NAMETABLE,
      REGION_PALETTE
   } region_type;

   typedef struct packed {
      region_type region;
      logic       is_write;
   } access_ctrl_type;

endpackage

// ===== src/ppbd_decode.sv =====
module ppbd_decode #(
   parameter int NAMETABLE_BYTES = ppbd_pkg::NAMETABLE_BYTES_DEFAULT,
   parameter int PALETTE_ENTRIES = ppbd_pkg::PALETTE_ENTRIES_DEFAULT,
   localparam int NtAw = $clog2(2 * NAMETABLE_BYTES),
   localparam int PalAw = $clog2(PALETTE_ENTRIES)
) (
   input  logic                          func,
   input  logic [ppbd_pkg::ADDR_WIDTH-1:0] address,
   input  logic                          mirroring_mode,
   output ppbd_pkg::access_ctrl_type     ctrl,
   output logic [NtAw-1:0]               nt_slot,
   output logic [PalAw-1:0]              pal_slot
);
   import ppbd_pkg::*;

   localparam int BankLsb = NtAw - 1;

   logic [ADDR_WIDTH-1:0] folded;
   logic [ADDR_WIDTH-1:0] offset;
   logic [1:0]            quadrant;
   logic                  bank;
   logic [ADDR_WIDTH-1:0] pal_masked;
   logic [PalAw-1:0]      pal_idx;

   always_comb begin
      ctrl.is_write = (func == FUNC_WRITE);
      if (address < NAMETABLE_BASE) begin
         ctrl.region = REGION_CARTRIDGE;
      end else if (address <= NAMETABLE_LAST) begin
         ctrl.region = REGION_NAMETABLE;
      end else begin
         ctrl.region = REGION_PALETTE;
      end
   end

   // 0x3000-0x3EFF mirrors 0x2000-0x2EFF
   assign folded   = (address >= MIRROR_BASE) ? (address - (MIRROR_BASE - NAMETABLE_BASE))
                                              : address;
   assign offset   = folded - NAMETABLE_BASE;
   assign quadrant = offset[BankLsb+1:BankLsb];
   assign bank     = (mirroring_mode == MIRROR_VERTICAL) ? quadrant[0] : quadrant[1];
   assign nt_slot  = {bank, folded[BankLsb-1:0]};

   // palette entries at multiples of four alias entry zero
   assign pal_masked = address & PALETTE_MASK;
   assign pal_idx    = pal_masked[PalAw-1:0];
   assign pal_slot   = (pal_idx[1:0] == 2'b00) ? '0 : pal_idx;

endmodule

// ===== src/ppbd_ram.sv =====
module ppbd_ram #(
   parameter int DEPTH = ppbd_pkg::PALETTE_ENTRIES_DEFAULT,
   localparam int Aw = $clog2(DEPTH)
) (
   input  logic                            clock,
   input  logic                            write_enable,
   input  logic                            read_enable,
   input  logic [Aw-1:0]                   addr,
   input  logic [ppbd_pkg::DATA_WIDTH-1:0] write_data,
   output logic [ppbd_pkg::DATA_WIDTH-1:0] read_data
);
   import ppbd_pkg::*;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem[addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== src/ppu_bus_nametable_palette_decode.sv =====
// Graphics bus decoder: cartridge pass-through flag, mirrored nametable RAM, palette RAM.
// The response strobes in the cycle after the request is taken (registered RAM read).
// Throughput: one request per clock; busy stays low, since each request makes at most a single
// read or a single write and the RAM write lands before the next request's read.
// Reset (synchronous, active high) clears the strobe and selects horizontal mirroring;
// RAM contents are undefined until written. The receiver cannot stall responses.
module ppu_bus_nametable_palette_decode #(
   parameter int NAMETABLE_BYTES = ppbd_pkg::NAMETABLE_BYTES_DEFAULT,
   parameter int PALETTE_ENTRIES = ppbd_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_func,
   input  logic [ppbd_pkg::ADDR_WIDTH-1:0] req_address,
   input  logic [ppbd_pkg::DATA_WIDTH-1:0] req_write_data,
   output logic                            rsp_strobe,
   output logic [ppbd_pkg::DATA_WIDTH-1:0] rsp_read_data,
   output logic                            rsp_cartridge_access,
   input  logic                            csr_write_enable,
   input  logic                            csr_write_data
);
   import ppbd_pkg::*;

   localparam int NtAw  = $clog2(2 * NAMETABLE_BYTES);
   localparam int PalAw = $clog2(PALETTE_ENTRIES);

   logic            mirroring_ff;
   logic            strobe_ff;
   logic            strobe_in;
   access_ctrl_type ctrl_ff;
   access_ctrl_type ctrl;
   logic            accept;
   logic [NtAw-1:0] nt_slot;
   logic [PalAw-1:0] pal_slot;
   logic [DATA_WIDTH-1:0] nt_rdata;
   logic [DATA_WIDTH-1:0] pal_rdata;
   logic            nt_sel;
   logic            pal_sel;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign strobe_in = accept;

   ppbd_decode #(
      .NAMETABLE_BYTES(NAMETABLE_BYTES),
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_decode (
      .func          (req_func),
      .address       (req_address),
      .mirroring_mode(mirroring_ff),
      .ctrl          (ctrl),
      .nt_slot       (nt_slot),
      .pal_slot      (pal_slot)
   );

   assign nt_sel  = accept && (ctrl.region == REGION_NAMETABLE);
   assign pal_sel = accept && (ctrl.region == REGION_PALETTE);

   ppbd_ram #(
      .DEPTH(2 * NAMETABLE_BYTES)
   ) u_nametable (
      .clock       (clock),
      .write_enable(nt_sel && ctrl.is_write),
      .read_enable (nt_sel && !ctrl.is_write),
      .addr        (nt_slot),
      .write_data  (req_write_data),
      .read_data   (nt_rdata)
   );

   ppbd_ram #(
      .DEPTH(PALETTE_ENTRIES)
   ) u_palette (
      .clock       (clock),
      .write_enable(pal_sel && ctrl.is_write),
      .read_enable (pal_sel && !ctrl.is_write),
      .addr        (pal_slot),
      .write_data  (req_write_data),
      .read_data   (pal_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff    <= 1'b0;
         mirroring_ff <= MIRROR_HORIZONTAL;
      end else begin
         strobe_ff <= strobe_in;
         if (csr_write_enable) begin
            mirroring_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctrl_ff <= ctrl;
      end
   end

   always_comb begin
      rsp_read_data = '0;
      if (!ctrl_ff.is_write) begin
         unique case (ctrl_ff.region)
            REGION_NAMETABLE: rsp_read_data = nt_rdata;
            REGION_PALETTE:   rsp_read_data = pal_rdata;
            REGION_CARTRIDGE: rsp_read_data = '0;
            default:          rsp_read_data = '0;
         endcase
      end
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_cartridge_access = (ctrl_ff.region == REGION_CARTRIDGE);

endmodule
